// ===== rtl/core/nnfs_pkg.sv =====
// Package for the nearest-neighbor flip scaler: sizes, register map,
// stream side-band bit positions and the size clamp helper.
// No dependencies.
package nnfs_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int DIM_W    = 9;                               // register width
    localparam int COORD_W  = $clog2(MAX_WIDTH);               // source column/row
    localparam int ROW_W    = 16;                              // output row, height
    localparam int STORE_AW = $clog2(MAX_WIDTH * MAX_HEIGHT);  // frame store address
    localparam int PIX_W    = 24;
    localparam int DIV_N    = 24;                              // dividend bits
    localparam int DIV_CW   = $clog2(DIV_N);
    localparam int CFG_AW   = 4;

    typedef logic [DIM_W-1:0]   dim_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [PIX_W-1:0]   pix_t;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TGT_WIDTH  = 2'd2;

    // input tuser: request kind
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // output tuser bits
    localparam int TUSER_EOF   = 0;
    localparam int TUSER_NOIMG = 1;

    // saturate to the limit, then force even
    function automatic dim_t even_sat(input dim_t v, input dim_t lim);
        dim_t s;
        s = (v > lim) ? lim : v;
        return {s[DIM_W-1:1], 1'b0};
    endfunction

endpackage

// ===== rtl/core/nearest_neighbor_flip_scaler.sv =====
// Nearest-neighbor frame scaler with vertical flip: frame store, APB registers,
// setup sequencer with a shared serial divider and incremental coordinate stepping.
// Depends on nnfs_pkg.
//
//  channel | direction | handshake              | content
//  --------+-----------+------------------------+--------------------------------------
//  s_      | in        | s_tvalid / s_tready    | tdata {blue,green,red}, tuser func
//  m_      | out       | m_tvalid / m_tready    | tdata {blue,green,red}, tlast end_of_row,
//          |           |                        | tuser {no_image,end_of_frame}
//  apb     | in        | psel & penable & pwrite| source_width, source_height, target_width
//
// A load or fetch request is taken on s_tvalid and s_tready; a fetch result shows in the
// next cycle from the frame store's registered read port, and a new request is taken while
// that result is being accepted. After reset and after every register write the setup
// sequencer runs up to six divides on the shared divider; s_tready stays low meanwhile.
// A stalled result holds and blocks further requests.
module nearest_neighbor_flip_scaler (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nnfs_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    input  logic [0:0]                  s_tuser,   // func[0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
    output logic                        m_tlast,   // end_of_row
    output logic [1:0]                  m_tuser    // end_of_frame[0], no_image[1]
);

    localparam logic [2:0] PH_TH  = 3'd0;
    localparam logic [2:0] PH_QX  = 3'd1;
    localparam logic [2:0] PH_QY  = 3'd2;
    localparam logic [2:0] PH_Y0  = 3'd3;
    localparam logic [2:0] PH_CX  = 3'd4;
    localparam logic [2:0] PH_CY  = 3'd5;
    localparam logic [2:0] PH_RUN = 3'd6;

    localparam int DW = nnfs_pkg::DIM_W;
    localparam int CW = nnfs_pkg::COORD_W;
    localparam int RW = nnfs_pkg::ROW_W;
    localparam int AW = nnfs_pkg::STORE_AW;
    localparam int DN = nnfs_pkg::DIV_N;
    localparam int DIV_CW_L = nnfs_pkg::DIV_CW;

    // registers
    nnfs_pkg::dim_t src_width_reg, src_height_reg, tgt_width_reg;
    nnfs_pkg::dim_t sw, sh, tw;

    // setup sequencer and divider
    logic [2:0]              phase_reg;
    logic                    launched_reg;
    logic                    div_busy_reg;
    logic [DIV_CW_L-1:0]     div_cnt_reg;
    logic [DN-1:0]           div_q_reg;
    logic [RW-1:0]           div_r_reg;
    logic [RW-1:0]           div_dvs_reg;

    // resampling state
    nnfs_pkg::row_t          th_reg;
    nnfs_pkg::coord_t        qx_reg;
    logic [DW-1:0]           rx_reg;
    logic [DW-1:0]           qy_reg;
    nnfs_pkg::row_t          ry_reg;
    nnfs_pkg::coord_t        sy0_reg;
    nnfs_pkg::row_t          ry0_reg;
    nnfs_pkg::coord_t        sx_reg;
    logic [DW-1:0]           rxa_reg;
    nnfs_pkg::coord_t        sy_reg;
    nnfs_pkg::row_t          rya_reg;
    nnfs_pkg::coord_t        col_reg;
    nnfs_pkg::row_t          row_reg;
    logic [AW-1:0]           lp_reg;

    // frame store and result
    nnfs_pkg::pix_t          store_mem [nnfs_pkg::MAX_WIDTH * nnfs_pkg::MAX_HEIGHT];
    nnfs_pkg::pix_t          rdata_reg;
    logic                    m_valid_reg;
    logic                    eor_reg, eof_reg, noimg_reg;

    logic                    cfg_wr;
    logic [1:0]              cfg_idx;
    logic                    run, in_acc, is_fetch;

    logic [RW-1:0]           mul_a;
    logic [DW-1:0]           mul_b;
    logic [RW+DW-1:0]        mul_p;
    logic [DN-1:0]           dvd_mux;
    logic [RW-1:0]           dvs_mux;
    nnfs_pkg::row_t          th_m1;
    logic                    div_start, div_done, div_ge;
    logic [RW:0]             div_trial, div_diff;
    logic [DN-1:0]           q_fin;
    logic [RW-1:0]           r_fin;
    nnfs_pkg::row_t          th_calc;
    logic                    stale;

    logic                    eor, eof, noimg;
    logic [DW:0]             xt;
    logic                    xwrap;
    logic [DW-1:0]           rxa_step;
    nnfs_pkg::coord_t        sx_step;
    logic                    ywrap;
    logic [RW:0]             ysum;
    nnfs_pkg::row_t          rya_step;
    nnfs_pkg::coord_t        sy_step;
    logic [CW+DW-1:0]        rd_prod;
    logic [AW-1:0]           rd_addr;
    logic [2*DW-1:0]         total, lp_inc;
    logic [AW-1:0]           lp_next;

    assign sw = nnfs_pkg::even_sat(src_width_reg,  DW'(nnfs_pkg::MAX_WIDTH));
    assign sh = nnfs_pkg::even_sat(src_height_reg, DW'(nnfs_pkg::MAX_HEIGHT));
    assign tw = nnfs_pkg::even_sat(tgt_width_reg,  DW'(nnfs_pkg::MAX_WIDTH));

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        unique case (cfg_idx)
            nnfs_pkg::REG_SRC_WIDTH:  prdata = 32'(src_width_reg);
            nnfs_pkg::REG_SRC_HEIGHT: prdata = 32'(src_height_reg);
            nnfs_pkg::REG_TGT_WIDTH:  prdata = 32'(tgt_width_reg);
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= DW'(256);
            src_height_reg <= DW'(256);
            tgt_width_reg  <= DW'(128);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                nnfs_pkg::REG_SRC_WIDTH:  src_width_reg  <= pwdata[DW-1:0];
                nnfs_pkg::REG_SRC_HEIGHT: src_height_reg <= pwdata[DW-1:0];
                nnfs_pkg::REG_TGT_WIDTH:  tgt_width_reg  <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    // stream handshake
    assign run      = (phase_reg == PH_RUN);
    assign s_tready = run && (!m_valid_reg || m_tready);
    assign in_acc   = s_tvalid && s_tready;
    assign is_fetch = (s_tuser[0] == nnfs_pkg::FUNC_FETCH);

    // shared setup multiplier and divider operands
    assign th_m1 = th_reg - RW'(1);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (phase_reg)
            PH_TH: begin
                mul_a = RW'(sh);
                mul_b = tw;
            end
            PH_Y0: begin
                mul_a = th_m1;
                mul_b = sh;
            end
            PH_CX: begin
                mul_a = RW'(col_reg);
                mul_b = sw;
            end
            PH_CY: begin
                mul_a = th_m1 - row_reg;
                mul_b = sh;
            end
            default: ;
        endcase
    end

    assign mul_p = (RW+DW)'(mul_a) * (RW+DW)'(mul_b);

    always_comb begin
        unique case (phase_reg)
            PH_QX:   dvd_mux = DN'(sw);
            PH_QY:   dvd_mux = DN'(sh);
            default: dvd_mux = mul_p[DN-1:0];
        endcase
        unique case (phase_reg)
            PH_TH:        dvs_mux = RW'(sw);
            PH_QX, PH_CX: dvs_mux = RW'(tw);
            default:      dvs_mux = th_reg;
        endcase
    end

    // restoring divider, one quotient bit a cycle
    assign div_start = !run && !launched_reg && !(phase_reg == PH_TH && sw == '0);
    assign div_trial = {div_r_reg, div_q_reg[DN-1]};
    assign div_ge    = (div_trial >= {1'b0, div_dvs_reg});
    assign div_diff  = div_trial - {1'b0, div_dvs_reg};
    assign r_fin     = div_ge ? div_diff[RW-1:0] : div_trial[RW-1:0];
    assign q_fin     = {div_q_reg[DN-2:0], div_ge};
    assign div_done  = div_busy_reg && (div_cnt_reg == DIV_CW_L'(DN - 1));
    assign th_calc   = {q_fin[RW-1:1], 1'b0};
    assign stale     = ({1'b0, col_reg} >= tw) || (row_reg >= th_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else if (cfg_wr) begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else if (div_start) begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end else if (div_busy_reg) begin
            div_busy_reg <= !div_done;
            div_cnt_reg  <= div_cnt_reg + DIV_CW_L'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (div_start) begin
            div_q_reg   <= dvd_mux;
            div_r_reg   <= '0;
            div_dvs_reg <= dvs_mux;
        end else if (div_busy_reg) begin
            div_q_reg <= q_fin;
            div_r_reg <= r_fin;
        end
    end

    // fetch stepping
    assign noimg = (th_reg == '0);
    assign eor   = ({1'b0, col_reg} == tw - DW'(1));
    assign eof   = eor && (row_reg == th_m1);

    assign xt       = {1'b0, rxa_reg} + {1'b0, rx_reg};
    assign xwrap    = (xt >= {1'b0, tw});
    assign rxa_step = xwrap ? DW'(xt - {1'b0, tw}) : xt[DW-1:0];
    assign sx_step  = CW'(DW'(sx_reg) + DW'(qx_reg) + DW'(xwrap));

    // descending rows: subtract sh/th per row, borrow from the remainder
    assign ywrap    = (rya_reg < ry_reg);
    assign ysum     = ywrap ? ({1'b0, rya_reg} + {1'b0, th_reg} - {1'b0, ry_reg})
                            : ({1'b0, rya_reg} - {1'b0, ry_reg});
    assign rya_step = ysum[RW-1:0];
    assign sy_step  = CW'(DW'(sy_reg) - qy_reg - DW'(ywrap));

    assign rd_prod = (CW+DW)'(sy_reg) * (CW+DW)'(sw) + (CW+DW)'(sx_reg);
    assign rd_addr = rd_prod[AW-1:0];

    // load position wraps at sw*sh
    assign total   = (2*DW)'(sw) * (2*DW)'(sh);
    assign lp_inc  = (2*DW)'(lp_reg) + (2*DW)'(1);
    assign lp_next = (total == '0 || lp_inc >= total) ? '0 : lp_inc[AW-1:0];

    // sequencer and coordinate state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_TH;
            launched_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            lp_reg       <= '0;
            th_reg       <= '0;
        end else if (cfg_wr) begin
            phase_reg    <= PH_TH;
            launched_reg <= 1'b0;
        end else if (!run) begin
            if (phase_reg == PH_TH && sw == '0) begin
                th_reg    <= '0;
                phase_reg <= PH_RUN;
            end else if (div_start) begin
                launched_reg <= 1'b1;
            end else if (div_done) begin
                launched_reg <= 1'b0;
                unique case (phase_reg)
                    PH_TH: begin
                        th_reg    <= th_calc;
                        phase_reg <= (th_calc == '0) ? PH_RUN : PH_QX;
                    end
                    PH_QX: begin
                        qx_reg    <= q_fin[CW-1:0];
                        rx_reg    <= r_fin[DW-1:0];
                        phase_reg <= PH_QY;
                    end
                    PH_QY: begin
                        qy_reg    <= q_fin[DW-1:0];
                        ry_reg    <= r_fin;
                        phase_reg <= PH_Y0;
                    end
                    PH_Y0: begin
                        sy0_reg   <= q_fin[CW-1:0];
                        ry0_reg   <= r_fin;
                        // restart the scan if the new sizes leave it out of range
                        if (stale) begin
                            col_reg <= '0;
                            row_reg <= '0;
                        end
                        phase_reg <= PH_CX;
                    end
                    PH_CX: begin
                        sx_reg    <= q_fin[CW-1:0];
                        rxa_reg   <= r_fin[DW-1:0];
                        phase_reg <= PH_CY;
                    end
                    PH_CY: begin
                        sy_reg    <= q_fin[CW-1:0];
                        rya_reg   <= r_fin;
                        phase_reg <= PH_RUN;
                    end
                    default: phase_reg <= PH_TH;
                endcase
            end
        end else if (in_acc) begin
            if (!is_fetch) begin
                lp_reg <= lp_next;
            end else if (!noimg) begin
                priority if (eof) begin
                    col_reg <= '0;
                    row_reg <= '0;
                    sx_reg  <= '0;
                    rxa_reg <= '0;
                    sy_reg  <= sy0_reg;
                    rya_reg <= ry0_reg;
                end else if (eor) begin
                    col_reg <= '0;
                    row_reg <= row_reg + RW'(1);
                    sx_reg  <= '0;
                    rxa_reg <= '0;
                    sy_reg  <= sy_step;
                    rya_reg <= rya_step;
                end else begin
                    col_reg <= col_reg + CW'(1);
                    sx_reg  <= sx_step;
                    rxa_reg <= rxa_step;
                end
            end
        end
    end

    // frame store: write on load, registered read on fetch
    always_ff @(posedge aclk) begin
        if (in_acc && !is_fetch) begin
            store_mem[lp_reg] <= s_tdata;
        end
        if (in_acc && is_fetch) begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_acc && is_fetch) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && is_fetch) begin
            noimg_reg <= noimg;
            eor_reg   <= eor && !noimg;
            eof_reg   <= eof && !noimg;
        end
    end

    assign m_tvalid                       = m_valid_reg;
    assign m_tdata                        = noimg_reg ? '0 : rdata_reg;
    assign m_tlast                        = eor_reg;
    assign m_tuser[nnfs_pkg::TUSER_EOF]   = eof_reg;
    assign m_tuser[nnfs_pkg::TUSER_NOIMG] = noimg_reg;

endmodule

// ===== rtl/core/nnfs_checker.sv =====
// Port-level checks for the nearest-neighbor flip scaler, bound to the top level.
// Depends on nnfs_pkg.
module nnfs_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [nnfs_pkg::CFG_AW-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata,
    input logic                        pready,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [23:0]                 s_tdata,
    input logic [0:0]                  s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [23:0]                 m_tdata,
    input logic                        m_tlast,
    input logic [1:0]                  m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // every new result follows a fetch request
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready
                                  && s_tuser[0] == nnfs_pkg::FUNC_FETCH))
        else $error("result without fetch request");

    // end of frame only at end of row
    a_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[nnfs_pkg::TUSER_EOF] |-> m_tlast)
        else $error("end of frame without end of row");

    // a no-image result carries no pixel and no markers
    a_noimg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[nnfs_pkg::TUSER_NOIMG] |->
            m_tdata == '0 && !m_tlast && !m_tuser[nnfs_pkg::TUSER_EOF])
        else $error("no-image result with payload");

endmodule

bind nearest_neighbor_flip_scaler nnfs_checker u_nnfs_checker (.*);
